FILE: hw/rtl/priority_boost_slot_table_top_assert.svh
// Assertion macros for the priority boost slot table.
`ifndef PRIORITY_BOOST_SLOT_TABLE_TOP_ASSERT_SVH
`define PRIORITY_BOOST_SLOT_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define PBST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbst: same-cycle check failed");
`define PBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbst: next-cycle check failed");
`else
`define PBST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/pbst_pkg.sv
package pbst_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int NEST_BITS  = 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int OP_W   = 2;
  localparam int TASK_W = 16;
  localparam int PRIO_W = 5;
  localparam int KIND_W = 2;

  localparam logic [PRIO_W-1:0]    BOOST_RESET = PRIO_W'(11);
  localparam logic [NEST_BITS-1:0] NEST_ONE    = NEST_BITS'(1);
  localparam logic [NEST_BITS-1:0] NEST_MAX    = {NEST_BITS{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ENTER = 2'd0,
    OP_LEAVE = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    logic              vld;
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
    logic [KIND_W-1:0] kind;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } lookup_t;

endpackage

FILE: hw/rtl/pbst_lookup.sv
module pbst_lookup (
  input  logic [pbst_pkg::SLOT_COUNT-1:0][pbst_pkg::TASK_W-1:0] owners_i,
  input  logic [pbst_pkg::TASK_W-1:0]                           task_id_i,
  output pbst_pkg::lookup_t                                     lookup_o
);
  import pbst_pkg::*;

  always_comb begin
    lookup_o = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (owners_i[i] == task_id_i) begin
        lookup_o.hit     = 1'b1;
        lookup_o.hit_idx = SLOT_IDX_W'(i);
      end
      if (owners_i[i] == '0) begin
        lookup_o.free     = 1'b1;
        lookup_o.free_idx = SLOT_IDX_W'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/pbst_core.sv
`include "priority_boost_slot_table_top_assert.svh"

module pbst_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbst_pkg::req_t              req_i,
  input  logic [pbst_pkg::PRIO_W-1:0] boost_i,
  output logic                        res_vld_o,
  output logic                        res_set_o,
  output logic [pbst_pkg::PRIO_W-1:0] res_prio_o,
  output logic                        res_held_o,
  output logic [pbst_pkg::KIND_W-1:0] res_kind_o,
  output logic                        res_exh_o
);
  import pbst_pkg::*;

  logic [SLOT_COUNT-1:0][TASK_W-1:0]    owner_q;
  logic [SLOT_COUNT-1:0][NEST_BITS-1:0] nest_q;
  logic [PRIO_W-1:0]                    saved_q [SLOT_COUNT];
  logic [KIND_W-1:0]                    kind_q  [SLOT_COUNT];
  logic                                 exh_seen_q;

  lookup_t               lk;
  logic [SLOT_IDX_W-1:0] slot_idx;
  logic [NEST_BITS-1:0]  cur_nest;
  logic [PRIO_W-1:0]     cur_saved;
  logic [KIND_W-1:0]     cur_kind;

  logic                  owner_we;
  logic [TASK_W-1:0]     owner_wdata;
  logic                  nest_we;
  logic [NEST_BITS-1:0]  nest_wdata;
  logic                  meta_we;
  logic                  exh_set;

  logic                  set_d;
  logic [PRIO_W-1:0]     prio_d;
  logic                  held_d;
  logic [KIND_W-1:0]     kind_d;
  logic                  exh_d;

  logic                  res_vld_q;
  logic                  set_q;
  logic [PRIO_W-1:0]     prio_q;
  logic                  held_q;
  logic [KIND_W-1:0]     res_kind_q;
  logic                  exh_q;

  pbst_lookup u_lookup (
    .owners_i  (owner_q),
    .task_id_i (req_i.task_id),
    .lookup_o  (lk)
  );

  assign slot_idx  = lk.hit ? lk.hit_idx : lk.free_idx;
  assign cur_nest  = nest_q[slot_idx];
  assign cur_saved = saved_q[slot_idx];
  assign cur_kind  = kind_q[slot_idx];

  always_comb begin
    owner_we    = 1'b0;
    owner_wdata = '0;
    nest_we     = 1'b0;
    nest_wdata  = '0;
    meta_we     = 1'b0;
    exh_set     = 1'b0;
    set_d       = 1'b0;
    prio_d      = '0;
    held_d      = 1'b0;
    kind_d      = '0;
    exh_d       = 1'b0;
    if (req_i.vld && (req_i.task_id != '0)) begin
      unique case (op_e'(req_i.op))
        OP_ENTER: begin
          if (lk.hit || lk.free) begin
            if (!lk.hit) begin
              owner_we    = 1'b1;
              owner_wdata = req_i.task_id;
            end
            nest_we    = 1'b1;
            nest_wdata = (cur_nest == NEST_MAX) ? cur_nest : cur_nest + NEST_ONE;
            meta_we    = (cur_nest == '0);
            if ((boost_i != '0) && (req_i.prio < boost_i)) begin
              set_d  = 1'b1;
              prio_d = boost_i;
            end
            held_d = 1'b1;
            kind_d = (cur_nest == '0) ? req_i.kind : cur_kind;
          end else if (!exh_seen_q) begin
            exh_set = 1'b1;
            exh_d   = 1'b1;
          end
        end
        OP_LEAVE: begin
          if (lk.hit && (cur_nest != '0)) begin
            nest_we    = 1'b1;
            nest_wdata = cur_nest - NEST_ONE;
            if (cur_nest == NEST_ONE) begin
              owner_we    = 1'b1;
              owner_wdata = '0;
              if (cur_saved != req_i.prio) begin
                set_d  = 1'b1;
                prio_d = cur_saved;
              end
            end else begin
              held_d = 1'b1;
              kind_d = cur_kind;
            end
          end else if (lk.hit) begin
            held_d = 1'b1;
          end
        end
        OP_QUERY: begin
          if (lk.hit) begin
            held_d = 1'b1;
            if (cur_nest != '0) begin
              kind_d = cur_kind;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q    <= '0;
      nest_q     <= '0;
      exh_seen_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (owner_we) begin
        owner_q[slot_idx] <= owner_wdata;
      end
      if (nest_we) begin
        nest_q[slot_idx] <= nest_wdata;
      end
      if (exh_set) begin
        exh_seen_q <= 1'b1;
      end
      res_vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      saved_q[slot_idx] <= req_i.prio;
      kind_q[slot_idx]  <= req_i.kind;
    end
    if (req_i.vld) begin
      set_q      <= set_d;
      prio_q     <= prio_d;
      held_q     <= held_d;
      res_kind_q <= kind_d;
      exh_q      <= exh_d;
    end
  end

  assign res_vld_o  = res_vld_q;
  assign res_set_o  = set_q;
  assign res_prio_o = prio_q;
  assign res_held_o = held_q;
  assign res_kind_o = res_kind_q;
  assign res_exh_o  = exh_q;

  `PBST_ASSERT_NEXT(a_res_follows_req, clk_i, rst_ni, req_i.vld, res_vld_q)
  `PBST_ASSERT_NEXT(a_no_spurious_res, clk_i, rst_ni, !req_i.vld, !res_vld_q)
  `PBST_ASSERT_NEXT(a_exh_once, clk_i, rst_ni, exh_seen_q && req_i.vld, !exh_q)
  `PBST_ASSERT_IMPLY(a_exh_not_held, clk_i, rst_ni, res_vld_q && exh_q, !held_q && !set_q)

endmodule

FILE: hw/rtl/priority_boost_slot_table_top.sv
// Channel  | Direction | Handshake          | Payload
// request  | in        | start_i, busy_o    | operation_i, task_id_i, current_priority_i,
//          |           |                    | use_kind_i
// result   | out       | done_o (strobe)    | set_priority_o, new_priority_o, slot_held_o,
//          |           |                    | held_kind_o, exhaustion_report_o
// config   | in        | cfg_we_i           | cfg_wdata_i (boost level)
//
// One request per cycle; busy_o stays low. A request taken by start_i is
// registered in req_q, matched against the eight-slot table and updated along
// with the result registers, and its result is strobed by done_o for a single cycle.
// The table lookup and update form one combinational pass between the request
// and result registers. Reset frees all slots, clears the exhaustion flag and
// loads a boost level of 11. Results cannot be stalled.
module priority_boost_slot_table_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [pbst_pkg::OP_W-1:0]   operation_i,
  input  logic [pbst_pkg::TASK_W-1:0] task_id_i,
  input  logic [pbst_pkg::PRIO_W-1:0] current_priority_i,
  input  logic [pbst_pkg::KIND_W-1:0] use_kind_i,
  input  logic                        cfg_we_i,
  input  logic [pbst_pkg::PRIO_W-1:0] cfg_wdata_i,
  output logic                        done_o,
  output logic                        set_priority_o,
  output logic [pbst_pkg::PRIO_W-1:0] new_priority_o,
  output logic                        slot_held_o,
  output logic [pbst_pkg::KIND_W-1:0] held_kind_o,
  output logic                        exhaustion_report_o
);
  import pbst_pkg::*;

  req_t              req_q;
  logic [PRIO_W-1:0] boost_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= '0;
      boost_q <= BOOST_RESET;
    end else begin
      req_q.vld <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        req_q.op      <= operation_i;
        req_q.task_id <= task_id_i;
        req_q.prio    <= current_priority_i;
        req_q.kind    <= use_kind_i;
      end
      if (cfg_we_i) begin
        boost_q <= cfg_wdata_i;
      end
    end
  end

  pbst_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_q),
    .boost_i    (boost_q),
    .res_vld_o  (done_o),
    .res_set_o  (set_priority_o),
    .res_prio_o (new_priority_o),
    .res_held_o (slot_held_o),
    .res_kind_o (held_kind_o),
    .res_exh_o  (exhaustion_report_o)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pbst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_GAP = 17;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS = 35;
  localparam logic [TASK_W-1:0] SAT_TASK = 16'hA5A5;

  typedef struct packed {
    logic              set_prio;
    logic [PRIO_W-1:0] new_prio;
    logic              held;
    logic [KIND_W-1:0] kind;
    logic              exhausted;
  } lock_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] id;
    logic [PRIO_W-1:0] prio;
    logic [KIND_W-1:0] kind;
    logic              typed;
    lock_result_t      want;
  } lock_row_t;

  localparam lock_result_t NO_LOCK    = '0;
  localparam lock_result_t BOOSTED_K3 = '{1'b1, 5'd11, 1'b1, 2'd3, 1'b0};
  localparam lock_result_t HELD_K3    = '{1'b0, 5'd0, 1'b1, 2'd3, 1'b0};
  localparam lock_result_t EXHAUSTED  = '{1'b0, 5'd0, 1'b0, 2'd0, 1'b1};
  localparam lock_result_t RESTORE_0  = '{1'b1, 5'd0, 1'b0, 2'd0, 1'b0};

  localparam lock_row_t LOCK_ROWS [22] = '{
    '{OP_QUERY,  16'h1234, 5'd0,  2'd0, 1'b1, NO_LOCK},
    '{OP_ENTER,  16'h0000, 5'd0,  2'd1, 1'b1, NO_LOCK},
    '{OP_UNUSED, 16'h0005, 5'd3,  2'd2, 1'b1, NO_LOCK},
    '{OP_LEAVE,  16'h0007, 5'd4,  2'd0, 1'b1, NO_LOCK},
    '{OP_ENTER,  16'hFFFF, 5'd0,  2'd3, 1'b1, BOOSTED_K3},
    '{OP_ENTER,  16'hFFFF, 5'd31, 2'd1, 1'b1, HELD_K3},
    '{OP_QUERY,  16'hFFFF, 5'd31, 2'd0, 1'b1, HELD_K3},
    '{OP_ENTER,  16'h0100, 5'd11, 2'd1, 1'b0, NO_LOCK},
    '{OP_ENTER,  16'h0101, 5'd12, 2'd2, 1'b0, NO_LOCK},
    '{OP_ENTER,  16'h0102, 5'd31, 2'd0, 1'b0, NO_LOCK},
    '{OP_ENTER,  16'h0103, 5'd5,  2'd3, 1'b0, NO_LOCK},
    '{OP_ENTER,  16'h0104, 5'd10, 2'd2, 1'b0, NO_LOCK},
    '{OP_ENTER,  16'h0105, 5'd0,  2'd1, 1'b0, NO_LOCK},
    '{OP_ENTER,  16'h0106, 5'd20, 2'd2, 1'b0, NO_LOCK},
    '{OP_ENTER,  16'h8000, 5'd0,  2'd1, 1'b1, EXHAUSTED},
    '{OP_ENTER,  16'h8001, 5'd0,  2'd1, 1'b1, NO_LOCK},
    '{OP_LEAVE,  16'hFFFF, 5'd31, 2'd0, 1'b1, HELD_K3},
    '{OP_LEAVE,  16'hFFFF, 5'd7,  2'd0, 1'b1, RESTORE_0},
    '{OP_ENTER,  16'h0001, 5'd10, 2'd2, 1'b0, NO_LOCK},
    '{OP_LEAVE,  16'h0001, 5'd10, 2'd0, 1'b0, NO_LOCK},
    '{OP_LEAVE,  16'h0101, 5'd11, 2'd0, 1'b0, NO_LOCK},
    '{OP_QUERY,  16'h0103, 5'd0,  2'd0, 1'b0, NO_LOCK}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [OP_W-1:0]     operation_i = '0;
  logic [TASK_W-1:0]   task_id_i = '0;
  logic [PRIO_W-1:0]   current_priority_i = '0;
  logic [KIND_W-1:0]   use_kind_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [PRIO_W-1:0]   cfg_wdata_i = '0;
  logic                done_o;
  logic                set_priority_o;
  logic [PRIO_W-1:0]   new_priority_o;
  logic                slot_held_o;
  logic [KIND_W-1:0]   held_kind_o;
  logic                exhaustion_report_o;

  logic [TASK_W-1:0]    tbl_owner [SLOT_COUNT];
  logic [PRIO_W-1:0]    tbl_saved_prio [SLOT_COUNT];
  logic [KIND_W-1:0]    tbl_kind [SLOT_COUNT];
  logic [NEST_BITS-1:0] tbl_nest [SLOT_COUNT];
  logic                 exhaust_seen;
  logic [PRIO_W-1:0]    boost_lvl;

  lock_result_t pending_results [$];
  lock_result_t oldest_result;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           request_no = 0;

  priority_boost_slot_table_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .operation_i        (operation_i),
    .task_id_i          (task_id_i),
    .current_priority_i (current_priority_i),
    .use_kind_i         (use_kind_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .set_priority_o     (set_priority_o),
    .new_priority_o     (new_priority_o),
    .slot_held_o        (slot_held_o),
    .held_kind_o        (held_kind_o),
    .exhaustion_report_o(exhaustion_report_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic lock_result_t predict_lock(input logic [OP_W-1:0] op,
                                                input logic [TASK_W-1:0] id,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [KIND_W-1:0] kind);
    lock_result_t r;
    int hit;
    int first_free;
    r = '0;
    hit = -1;
    first_free = -1;
    if (id == '0 || op == OP_UNUSED) return r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit < 0 && tbl_owner[i] == id) hit = i;
      if (first_free < 0 && tbl_owner[i] == '0) first_free = i;
    end
    case (op)
      OP_ENTER: begin
        if (hit < 0 && first_free >= 0) begin
          hit = first_free;
          tbl_owner[hit] = id;
        end
        if (hit >= 0) begin
          if (tbl_nest[hit] == '0) begin
            tbl_saved_prio[hit] = prio;
            tbl_kind[hit] = kind;
          end
          if (tbl_nest[hit] != NEST_MAX) tbl_nest[hit] = tbl_nest[hit] + NEST_ONE;
          if (boost_lvl != '0 && prio < boost_lvl) begin
            r.set_prio = 1'b1;
            r.new_prio = boost_lvl;
          end
          r.held = 1'b1;
          r.kind = tbl_kind[hit];
        end else if (!exhaust_seen) begin
          exhaust_seen = 1'b1;
          r.exhausted = 1'b1;
        end
      end
      OP_LEAVE: begin
        if (hit >= 0 && tbl_nest[hit] != '0) begin
          tbl_nest[hit] = tbl_nest[hit] - NEST_ONE;
          if (tbl_nest[hit] == '0) begin
            tbl_owner[hit] = '0;
            if (tbl_saved_prio[hit] != prio) begin
              r.set_prio = 1'b1;
              r.new_prio = tbl_saved_prio[hit];
            end
          end else begin
            r.held = 1'b1;
            r.kind = tbl_kind[hit];
          end
        end else if (hit >= 0) begin
          r.held = 1'b1;
        end
      end
      default: begin
        if (hit >= 0) begin
          r.held = 1'b1;
          if (tbl_nest[hit] != '0) r.kind = tbl_kind[hit];
        end
      end
    endcase
    return r;
  endfunction

  task automatic issue_request(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id,
                               input logic [PRIO_W-1:0] prio, input logic [KIND_W-1:0] kind,
                               input logic typed, input lock_result_t want);
    lock_result_t predicted;
    int gap;
    gap = (request_no % 40 < 12) ? 0 : $urandom_range(0, MAX_GAP);
    request_no++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i            <= 1'b1;
    operation_i        <= op;
    task_id_i          <= id;
    current_priority_i <= prio;
    use_kind_i         <= kind;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predicted = predict_lock(op, id, prio, kind);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_boost(input logic [PRIO_W-1:0] lvl);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lvl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    boost_lvl = lvl;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (set_priority_o !== oldest_result.set_prio) begin
          $error("set_priority expected %0d actual %0d", oldest_result.set_prio,
                 set_priority_o);
          fail_count++;
        end
        if (new_priority_o !== oldest_result.new_prio) begin
          $error("new_priority expected %0d actual %0d", oldest_result.new_prio,
                 new_priority_o);
          fail_count++;
        end
        if (slot_held_o !== oldest_result.held) begin
          $error("slot_held expected %0d actual %0d", oldest_result.held, slot_held_o);
          fail_count++;
        end
        if (held_kind_o !== oldest_result.kind) begin
          $error("held_kind expected %0d actual %0d", oldest_result.kind, held_kind_o);
          fail_count++;
        end
        if (exhaustion_report_o !== oldest_result.exhausted) begin
          $error("exhaustion_report expected %0d actual %0d", oldest_result.exhausted,
                 exhaustion_report_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [TASK_W-1:0] id_pool [12];
    logic [TASK_W-1:0] id;
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] lvl;
    int                pick;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_owner[i]      = '0;
      tbl_saved_prio[i] = '0;
      tbl_kind[i]       = '0;
      tbl_nest[i]       = '0;
    end
    exhaust_seen = 1'b0;
    boost_lvl    = BOOST_RESET;
    for (int i = 0; i < 12; i++) begin
      id_pool[i] = (i < 7) ? TASK_W'(16'h0100 + i) : TASK_W'($urandom_range(1, 65535));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (LOCK_ROWS[r]) begin
      issue_request(LOCK_ROWS[r].op, LOCK_ROWS[r].id, LOCK_ROWS[r].prio, LOCK_ROWS[r].kind,
                    LOCK_ROWS[r].typed, LOCK_ROWS[r].want);
    end

    // drive one slot past its nesting limit, then unwind it and leave once more
    write_boost(5'd31);
    for (int n = 0; n < 257; n++) begin
      issue_request(OP_ENTER, SAT_TASK, PRIO_W'($urandom_range(0, 31)),
                    KIND_W'($urandom_range(0, 3)), 1'b0, NO_LOCK);
    end
    for (int n = 0; n < 256; n++) begin
      issue_request(OP_LEAVE, SAT_TASK, PRIO_W'($urandom_range(0, 31)),
                    KIND_W'($urandom_range(0, 3)), 1'b0, NO_LOCK);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: lvl = 5'd0;
        1: lvl = 5'd1;
        2: lvl = 5'd31;
        default: lvl = PRIO_W'($urandom_range(0, 31));
      endcase
      write_boost(lvl);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) op = OP_ENTER;
        else if (pick < 15) op = OP_LEAVE;
        else if (pick < 19) op = OP_QUERY;
        else op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 8) id = '0;
        else if (pick < 23) id = TASK_W'($urandom);
        else id = id_pool[$urandom_range(0, 11)];
        issue_request(op, id, PRIO_W'($urandom_range(0, 31)),
                      KIND_W'($urandom_range(0, 3)), 1'b0, NO_LOCK);
      end
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/pbst_pkg.sv
hw/rtl/pbst_lookup.sv
hw/rtl/pbst_core.sv
hw/rtl/priority_boost_slot_table_top.sv
tb/tb_top.sv
